/* design/chd_pkg.sv */
// Shared types, constants and decode functions of the chunked transfer decoder.
package chd_pkg;

    // Default width of the chunk size and byte counters
    localparam int COUNT_BITS_DEF = 32;

    // Decoder phase codes
    localparam logic [2:0] PH_BLANK = 3'd0;
    localparam logic [2:0] PH_DIGIT = 3'd1;
    localparam logic [2:0] PH_TAIL  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_TRAIL = 3'd4;
    localparam logic [2:0] PH_ENDED = 3'd5;

    localparam logic [1:0] TRAILER_LEN = 2'd2;
    localparam logic [7:0] LINE_FEED   = 8'h0A;

    // One input transaction
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       stream_end;
    } chd_item_t;

    // One result transaction
    typedef struct packed {
        logic [7:0] body_byte;
        logic       has_data;
        logic       done_res;
        logic       end_cause;
    } chd_result_t;

    // Hex digit decode: bit 4 set when the byte is a hex digit, value in bits 3:0
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (b >= 8'h30 && b <= 8'h39)
            begin
                r = {1'b1, 4'(b - 8'h30)};
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                r = {1'b1, 4'(b - 8'h37)};
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                r = {1'b1, 4'(b - 8'h57)};
            end
            return r;
        end
    endfunction

    // Space, tab, CR, VT or FF
    function automatic logic is_blank(input logic [7:0] b);
        begin
            return (b == 8'h20) || (b == 8'h09) || (b == 8'h0D) ||
                   (b == 8'h0B) || (b == 8'h0C);
        end
    endfunction

endpackage

/* design/chd_in_reg.sv */
// Input register of the chunked transfer decoder.
module chd_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  chd_pkg::chd_item_t in_item,
    input  logic               take,
    output logic               held_valid,
    output chd_pkg::chd_item_t held_item
);

    logic               valid_reg;
    logic               valid_next;
    chd_pkg::chd_item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

/* design/chd_framer.sv */
// Chunk framing state machine: size line parse, payload count and trailer skip.
module chd_framer
#(
    parameter int COUNT_BITS = chd_pkg::COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  chd_pkg::chd_item_t   item,
    output logic                 res_valid,
    output chd_pkg::chd_result_t res
);

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic [COUNT_BITS-1:0] size_reg;
    logic [COUNT_BITS-1:0] size_next;
    logic [COUNT_BITS-1:0] left_reg;
    logic [COUNT_BITS-1:0] left_next;
    logic [1:0]            skip_reg;
    logic [1:0]            skip_next;

    logic [4:0]            hex;
    logic                  blank;
    logic                  lf;
    logic [COUNT_BITS-1:0] size_dig;
    logic [COUNT_BITS-1:0] left_dec;
    logic [1:0]            skip_dec;
    logic                  data;
    logic                  ended;

    assign hex      = chd_pkg::hex_decode(item.stream_byte);
    assign blank    = chd_pkg::is_blank(item.stream_byte);
    assign lf       = (item.stream_byte == chd_pkg::LINE_FEED);
    assign left_dec = left_reg - COUNT_BITS'(1);
    assign skip_dec = skip_reg - 2'd1;

    // Append one hex digit, saturating once the top nibble is in use
    assign size_dig = (size_reg[COUNT_BITS-1 -: 4] != 4'd0) ? {COUNT_BITS{1'b1}}
                                                             : {size_reg[COUNT_BITS-5:0], hex[3:0]};

    // Next state of the framing machine
    always_comb
    begin
        phase_next = phase_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        skip_next  = skip_reg;
        data       = 1'b0;
        case (phase_reg)
            chd_pkg::PH_BLANK:
            begin
                if (blank)
                begin
                    phase_next = chd_pkg::PH_BLANK;
                end
                else if (hex[4])
                begin
                    size_next  = size_dig;
                    phase_next = chd_pkg::PH_DIGIT;
                end
                else
                begin
                    // no digits at all: size zero ends decoding
                    phase_next = chd_pkg::PH_ENDED;
                end
            end
            chd_pkg::PH_DIGIT:
            begin
                if (hex[4])
                begin
                    size_next = size_dig;
                end
                else if (size_reg == '0)
                begin
                    phase_next = chd_pkg::PH_ENDED;
                end
                else if (lf)
                begin
                    phase_next = chd_pkg::PH_DATA;
                    left_next  = size_reg;
                end
                else
                begin
                    phase_next = chd_pkg::PH_TAIL;
                end
            end
            chd_pkg::PH_TAIL:
            begin
                if (lf)
                begin
                    phase_next = chd_pkg::PH_DATA;
                    left_next  = size_reg;
                end
            end
            chd_pkg::PH_DATA:
            begin
                data      = 1'b1;
                left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = chd_pkg::PH_TRAIL;
                    skip_next  = chd_pkg::TRAILER_LEN;
                end
            end
            chd_pkg::PH_TRAIL:
            begin
                skip_next = skip_dec;
                if (skip_dec == 2'd0)
                begin
                    phase_next = chd_pkg::PH_BLANK;
                    size_next  = '0;
                end
            end
            default:
            begin
                phase_next = chd_pkg::PH_ENDED;
            end
        endcase
        ended = (phase_next == chd_pkg::PH_ENDED);

        // Final byte of a body: start afresh for the next one
        if (item.stream_end)
        begin
            phase_next = chd_pkg::PH_BLANK;
            size_next  = '0;
            left_next  = '0;
            skip_next  = 2'd0;
        end
    end

    // Result of the current byte
    assign res_valid     = data || item.stream_end;
    assign res.body_byte = data ? item.stream_byte : 8'd0;
    assign res.has_data  = data;
    assign res.done_res  = item.stream_end;
    assign res.end_cause = item.stream_end && !ended;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= chd_pkg::PH_BLANK;
            size_reg  <= '0;
            left_reg  <= '0;
            skip_reg  <= 2'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

/* design/chd_out_reg.sv */
// Result register of the chunked transfer decoder.
module chd_out_reg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 res_valid,
    input  chd_pkg::chd_result_t res,
    output logic                 space,
    output logic                 out_valid,
    input  logic                 out_ready,
    output chd_pkg::chd_result_t out_res
);

    logic                 valid_reg;
    logic                 valid_next;
    chd_pkg::chd_result_t res_reg;

    // Room when empty or when the waiting result leaves this cycle
    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg && !out_ready;
        if (load)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

/* design/http_chunked_decoder.sv */
// Top level of the HTTP chunked transfer decoder.
//
//  Channel   Dir  tdata                tlast       tuser
//  s_axis    in   [7:0] stream_byte    stream_end  -
//  m_axis    out  [7:0] body_byte      done_res    [0] has_data, [1] end_cause
//
// One byte is taken every clock while m_axis is not stalled. A result is valid on
// m_axis once its byte has sat in the input register and the framing logic has
// loaded the result register.
// Bytes that give no result (size lines, trailers, bytes after the end) are
// dropped silently. A stall on m_axis holds the result register and then the
// input register; s_axis_tready follows m_axis_tready within the same cycle.
// Reset clears the framing state to the start of a size line.
module http_chunked_decoder
#(
    parameter int COUNT_BITS = chd_pkg::COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] stream_byte
    input  logic       s_axis_tlast,   // stream_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] body_byte
    output logic       m_axis_tlast,   // done_res
    output logic [1:0] m_axis_tuser    // [0] has_data, [1] end_cause
);

    chd_pkg::chd_item_t   in_item;
    chd_pkg::chd_item_t   held_item;
    chd_pkg::chd_result_t res;
    chd_pkg::chd_result_t out_res;
    logic                 held_valid;
    logic                 res_valid;
    logic                 space;
    logic                 advance;

    assign in_item.stream_byte = s_axis_tdata;
    assign in_item.stream_end  = s_axis_tlast;

    // The held byte is processed when the result register can take its result
    assign advance = held_valid && space;

    chd_in_reg u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .take       (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    chd_framer #(.COUNT_BITS(COUNT_BITS)) u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (held_item),
        .res_valid (res_valid),
        .res       (res)
    );

    chd_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_valid (res_valid),
        .res       (res),
        .space     (space),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.body_byte;
    assign m_axis_tlast = out_res.done_res;
    assign m_axis_tuser = {out_res.end_cause, out_res.has_data};

endmodule

/* design/chd_checker.sv */
// Port-level assertions for the chunked transfer decoder, bound to the top level.
module chd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [1:0] m_axis_tuser
);

    // A stalled result transaction holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
            $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Every result carries a payload byte or closes a body
    a_out_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser[0] || m_axis_tlast)
        else $error("result with neither data nor done");

    // Non-payload results carry a zero byte
    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 8'd0)
        else $error("non-payload result with non-zero byte");

    // End cause only on the closing result
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("end cause set without done");

    // The input side is never held off while the result side is ready
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while result side ready");

endmodule

bind http_chunked_decoder chd_checker u_chd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

/* bench/chd_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the chunked decoder: predicts each result from accepted bytes and compares.
module chd_scoreboard
#(
    parameter int COUNT_BITS = chd_pkg::COUNT_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] stream_byte
    input  logic       s_axis_tlast,   // stream_end
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] body_byte
    input  logic       m_axis_tlast,   // done_res
    input  logic [1:0] m_axis_tuser,   // [0] has_data, [1] end_cause
    output int         fail_count,
    output int         pending
);

    import chd_pkg::*;

    localparam logic [COUNT_BITS-1:0] SIZE_MAX = '1;

    // Predicted framing state
    logic [2:0]            phase_q;
    logic [COUNT_BITS-1:0] size_q;
    logic [COUNT_BITS-1:0] left_q;
    logic [1:0]            skip_q;

    chd_result_t decoded_q[$];
    int          errors = 0;

    // Bit 4 flags a hex digit, bits 3:0 hold its value
    function automatic logic [4:0] nibble_of(input logic [7:0] b);
        logic [4:0] v;
        v = 5'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            v = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            v = {1'b1, b[3:0] + 4'd9};
        end
        return v;
    endfunction

    // Space, or tab through CR except the line feed
    function automatic logic blank_char(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D && b != LINE_FEED);
    endfunction

    task automatic clear_state();
        phase_q = PH_BLANK;
        size_q  = '0;
        left_q  = '0;
        skip_q  = '0;
    endtask

    // Shift in one hex digit, sticking at the counter maximum
    task automatic add_nibble(input logic [3:0] d);
        if (size_q > ((SIZE_MAX - COUNT_BITS'(d)) >> 4))
        begin
            size_q = SIZE_MAX;
        end
        else
        begin
            size_q = (size_q << 4) | COUNT_BITS'(d);
        end
    endtask

    // Size is fixed: zero ends the body, otherwise move on
    task automatic close_size(input logic [2:0] next);
        if (size_q == '0)
        begin
            phase_q = PH_ENDED;
        end
        else
        begin
            phase_q = next;
            if (next == PH_DATA)
            begin
                left_q = size_q;
            end
        end
    endtask

    // Advance the framing state by one byte and queue any result it gives
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [4:0]  hv;
        logic        is_data;
        chd_result_t r;
        hv      = nibble_of(b);
        is_data = 1'b0;
        case (phase_q)
            PH_BLANK:
            begin
                if (blank_char(b))
                begin
                end
                else if (hv[4])
                begin
                    add_nibble(hv[3:0]);
                    phase_q = PH_DIGIT;
                end
                else
                begin
                    close_size(PH_TAIL);
                end
            end
            PH_DIGIT:
            begin
                if (hv[4])
                begin
                    add_nibble(hv[3:0]);
                end
                else if (b == LINE_FEED)
                begin
                    close_size(PH_DATA);
                end
                else
                begin
                    close_size(PH_TAIL);
                end
            end
            PH_TAIL:
            begin
                if (b == LINE_FEED)
                begin
                    phase_q = PH_DATA;
                    left_q  = size_q;
                end
            end
            PH_DATA:
            begin
                is_data = 1'b1;
                left_q  = left_q - COUNT_BITS'(1);
                if (left_q == '0)
                begin
                    phase_q = PH_TRAIL;
                    skip_q  = TRAILER_LEN;
                end
            end
            PH_TRAIL:
            begin
                skip_q = skip_q - 2'd1;
                if (skip_q == 2'd0)
                begin
                    phase_q = PH_BLANK;
                    size_q  = '0;
                end
            end
            default:
            begin
                phase_q = PH_ENDED;
            end
        endcase

        if (is_data || fin)
        begin
            r.body_byte = is_data ? b : 8'h00;
            r.has_data  = is_data;
            r.done_res  = fin;
            r.end_cause = fin && (phase_q != PH_ENDED);
            decoded_q.push_back(r);
        end
        // a finished body leaves the decoder ready for the next one
        if (fin)
        begin
            clear_state();
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    // Compare one result transaction against the oldest prediction
    task automatic check_result();
        chd_result_t want;
        if (decoded_q.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual tdata %h tlast %b tuser %b",
                     $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
            errors++;
        end
        else
        begin
            want = decoded_q.pop_front();
            check_field("body_byte", want.body_byte, m_axis_tdata);
            check_field("has_data", 8'(want.has_data), 8'(m_axis_tuser[0]));
            check_field("done_res", 8'(want.done_res), 8'(m_axis_tlast));
            check_field("end_cause", 8'(want.end_cause), 8'(m_axis_tuser[1]));
        end
    endtask

    // Results are checked before this edge's byte is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            decoded_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_result();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_byte(s_axis_tdata, s_axis_tlast);
            end
            fail_count <= errors;
            pending    <= decoded_q.size();
        end
    end

endmodule

/* bench/http_chunked_decoder_test.sv */
`timescale 1ns / 100ps
// Top of the chunked decoder bench: clock, reset, byte stimulus, back-pressure and verdict.
module http_chunked_decoder_test;

    import chd_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [1:0] m_axis_tuser;

    int fail_count;
    int pending;

    chd_item_t stim_q[$];
    logic      quiet;
    int        src_gap_pct;
    int        sink_stall_pct;

    http_chunked_decoder uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    chd_scoreboard frame_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    always #2 clk = ~clk;

    task automatic put(input logic [7:0] b, input logic e);
        chd_item_t it;
        it.stream_byte = b;
        it.stream_end  = e;
        stim_q.push_back(it);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put(s[i], 1'b0);
        end
    endtask

    // Hex digit character, letters in random case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (($urandom_range(0, 1) == 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0:       return 8'h20;
            1:       return 8'h09;
            2:       return 8'h0D;
            3:       return 8'h0B;
            default: return 8'h0C;
        endcase
    endfunction

    function automatic logic [7:0] not_lf();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom);
        end
        while (b == LINE_FEED);
        return b;
    endfunction

    // One body: mostly well-formed chunk sequences, some noise, some cut short
    task automatic make_body();
        int        start;
        int        kind;
        int        nchunk;
        int        sz;
        int        cut;
        logic      huge;
        chd_item_t it;
        start = stim_q.size();
        kind  = $urandom_range(0, 99);
        huge  = 1'b0;
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 8)) put(8'($urandom), 1'b0);
        end
        else
        begin
            nchunk = $urandom_range(1, 4);
            for (int c = 0; c < nchunk && !huge; c++)
            begin
                repeat ($urandom_range(0, 2)) put(pick_blank(), 1'b0);
                if ($urandom_range(0, 19) == 0)
                begin
                    // long digit run: saturates or far exceeds what follows
                    huge = 1'b1;
                    put(hex_char(4'($urandom_range(1, 15))), 1'b0);
                    repeat ($urandom_range(4, 10)) put(hex_char(4'($urandom)), 1'b0);
                    sz = $urandom_range(1, 5);
                end
                else
                begin
                    sz = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                     : $urandom_range(1, 6);
                    repeat ($urandom_range(0, 2)) put(8'h30, 1'b0);
                    if (sz > 15)
                    begin
                        put(hex_char(4'(sz >> 4)), 1'b0);
                    end
                    put(hex_char(4'(sz)), 1'b0);
                end
                if ($urandom_range(0, 9) < 3)
                begin
                    put_text(";");
                    repeat ($urandom_range(0, 3)) put(not_lf(), 1'b0);
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    put(8'h0D, 1'b0);
                end
                put(LINE_FEED, 1'b0);
                repeat (sz) put(8'($urandom), 1'b0);
                if (!huge)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        put(8'($urandom), 1'b0);
                        put(8'($urandom), 1'b0);
                    end
                    else
                    begin
                        put(8'h0D, 1'b0);
                        put(LINE_FEED, 1'b0);
                    end
                end
            end
            if (!huge)
            begin
                // closing zero chunk, sometimes with swallowed bytes after it
                repeat ($urandom_range(0, 1)) put(pick_blank(), 1'b0);
                put_text("0");
                put(8'h0D, 1'b0);
                put(LINE_FEED, 1'b0);
                put(8'h0D, 1'b0);
                put(LINE_FEED, 1'b0);
                repeat ($urandom_range(0, 3)) put(8'($urandom), 1'b0);
            end
        end
        // stream sometimes stops early
        cut = stim_q.size() - start - 1;
        if (kind >= 10 && kind < 25)
        begin
            cut = $urandom_range(0, cut);
        end
        while (stim_q.size() > start + cut + 1)
        begin
            it = stim_q.pop_back();
        end
        it = stim_q.pop_back();
        it.stream_end = 1'b1;
        stim_q.push_back(it);
    endtask

    // Receiver: random stall bursts, none once the run gets quiet
    initial
    begin : sink_side
        int stall;
        stall = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                stall--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 99) < sink_stall_pct)
            begin
                stall = $urandom_range(1, 6) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Sender and verdict
    initial
    begin : source_side
        int n_directed;
        int quiet_from;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = 8'h00;
        s_axis_tlast   = 1'b0;
        quiet          = 1'b0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;

        // every kind of leading blank, size with extension, extreme data bytes
        put(8'h20, 1'b0);
        put(8'h09, 1'b0);
        put(8'h0B, 1'b0);
        put(8'h0C, 1'b0);
        put(8'h0D, 1'b0);
        put_text("2;");
        put(LINE_FEED, 1'b0);
        put(8'h00, 1'b0);
        put(8'hFF, 1'b0);
        put(8'h0D, 1'b0);
        put(LINE_FEED, 1'b0);
        // zero-size chunk; the swallowed byte after it carries the end
        put_text("0");
        put(LINE_FEED, 1'b0);
        put(8'h5A, 1'b1);
        // line feed among the leading blanks ends decoding at once
        put(LINE_FEED, 1'b0);
        put(8'h71, 1'b1);
        // size overflow saturates, then the stream runs out inside the chunk
        put_text("fFFFFFFFF");
        put(LINE_FEED, 1'b0);
        put(8'hA5, 1'b0);
        put(8'h3C, 1'b1);
        n_directed = stim_q.size();

        while (stim_q.size() < n_directed + 400)
        begin
            make_body();
        end
        quiet_from = stim_q.size() * 85 / 100;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < stim_q.size(); i++)
        begin
            if (i % 50 == 0)
            begin
                src_gap_pct    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
                sink_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            end
            quiet = (i >= quiet_from);
            if (i == n_directed || i == stim_q.size() / 2)
            begin
                // hold off until every owed result has been delivered
                s_axis_tvalid <= 1'b0;
                do
                begin
                    @(posedge clk);
                end
                while (pending != 0);
            end
            else if (!quiet && $urandom_range(0, 99) < src_gap_pct)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim_q[i].stream_byte;
            s_axis_tlast  <= stim_q[i].stream_end;
            do
            begin
                @(posedge clk);
            end
            while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then keep waiting for stray results
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Run limit
    initial
    begin : watchdog
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
